/* design/odcc_pkg.sv */
`timescale 1ns / 1ps

package odcc_pkg;

	// function codes of an input item
	localparam logic [1:0] FUNC_CULL  = 2'd0;
	localparam logic [1:0] FUNC_PUSH  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_FAR_MULT  = 2'd0;
	localparam logic [1:0] REG_FORWARD_X = 2'd1;
	localparam logic [1:0] REG_FORWARD_Y = 2'd2;
	localparam logic [1:0] REG_FORWARD_Z = 2'd3;

	localparam logic [3:0] FAR_MULT_RESET = 4'd4;

	// queue select codes
	localparam logic [1:0] QSEL_NONE = 2'd0;
	localparam logic [1:0] QSEL_A    = 2'd1;
	localparam logic [1:0] QSEL_B    = 2'd2;
	localparam logic [1:0] QSEL_C    = 2'd3;

	// object classes
	localparam logic [7:0] TYPE_A0 = 8'd2;
	localparam logic [7:0] TYPE_A1 = 8'd9;
	localparam logic [7:0] TYPE_B  = 8'd4;
	localparam logic [7:0] TYPE_C  = 8'd5;

	localparam logic [7:0] MODE_FORCE_TWO = 8'd4;
	localparam logic [2:0] STATE_FORCED   = 3'd2;
	localparam logic [2:0] STATE_KEEP_MIN = 3'd5;

	// default queue caps
	localparam int QUEUE_A_CAP_DEF = 24;
	localparam int QUEUE_B_CAP_DEF = 40;
	localparam int QUEUE_C_CAP_DEF = 28;

	// shared multiplier operations
	localparam logic [2:0] MUL_SQ_X  = 3'd0;
	localparam logic [2:0] MUL_SQ_Y  = 3'd1;
	localparam logic [2:0] MUL_SQ_Z  = 3'd2;
	localparam logic [2:0] MUL_DOT_X = 3'd3;
	localparam logic [2:0] MUL_DOT_Y = 3'd4;
	localparam logic [2:0] MUL_DOT_Z = 3'd5;
	localparam logic [2:0] MUL_FAR   = 3'd6;
	localparam logic [2:0] MUL_THR   = 3'd7;

	localparam int SQRT_STEPS = 16;

	// distance limits
	localparam logic [10:0] NEAR_512  = 11'd512;
	localparam logic [10:0] NEAR_768  = 11'd768;
	localparam logic [10:0] NEAR_1024 = 11'd1024;
	localparam logic [12:0] FAR_7169  = 13'd7169;
	localparam logic [12:0] FAR_6657  = 13'd6657;
	localparam logic [12:0] FAR_6145  = 13'd6145;
	localparam logic [12:0] FAR_5121  = 13'd5121;
	localparam logic [12:0] FAR_4097  = 13'd4097;
	localparam logic [9:0]  THR_880   = 10'd880;
	localparam logic [9:0]  THR_872   = 10'd872;
	localparam logic [9:0]  THR_856   = 10'd856;
	localparam logic [9:0]  THR_848   = 10'd848;

	typedef struct packed {
		logic [10:0] near;
		logic [12:0] far;
		logic [9:0]  thr;
	} limits_t;

	typedef struct packed {
		logic       load;
		logic       mul_go;
		logic [2:0] mul_op;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       decide;
	} cmd_t;

	typedef struct packed {
		logic is_cull;
	} sts_t;

	function automatic limits_t limits_of(logic [2:0] st, logic [7:0] ty);
		limits_t l;
		begin
			l = '{near: NEAR_1024, far: FAR_6657, thr: THR_872};
			case (st)
				3'd0: begin
					l.near = NEAR_512;
					if (ty == TYPE_B) begin
						l.far = FAR_7169;
						l.thr = THR_856;
					end else if (ty == TYPE_A0 || ty == TYPE_A1) begin
						l.far = FAR_5121;
						l.thr = THR_880;
					end else if (ty == TYPE_C) begin
						l.far = FAR_6657;
						l.thr = THR_872;
					end else begin
						l.far = FAR_6145;
						l.thr = THR_872;
					end
				end
				3'd1: l = '{near: NEAR_512, far: FAR_7169, thr: THR_856};
				3'd2: l = '{near: NEAR_768, far: FAR_4097, thr: THR_880};
				3'd3: l = '{near: NEAR_512, far: FAR_4097, thr: THR_848};
				default: l = '{near: NEAR_1024, far: FAR_6657, thr: THR_872};
			endcase
			return l;
		end
	endfunction

	function automatic logic [1:0] class_queue(logic [7:0] ty);
		logic [1:0] q;
		begin
			case (ty)
				TYPE_B:          q = QSEL_B;
				TYPE_A0, TYPE_A1: q = QSEL_A;
				TYPE_C:          q = QSEL_C;
				default:         q = QSEL_NONE;
			endcase
			return q;
		end
	endfunction

endpackage

/* design/object_distance_cone_cull.sv */
`timescale 1ns / 1ps

// channel   handshake                 payload
// in        in_valid / in_stall       func, obj_handle, obj_type, delta_x/y/z,
//                                     cull_state, mode_byte, queue_suppress
// out       out_valid / out_stall     visible, forced_state_two, queue_sel, pushed,
//                                     queue_count, obj_out
// cfg       cfg_we, cfg_index         cfg_data (far_multiplier, forward_x/y/z)
//
// a cull transfer runs from accept to the next accept through seven operations on
//   the shared 17x17 multiplier, 16 steps of the one-bit-per-cycle square root, one
//   multiply for the depth threshold, a land state for that product and a decide
//   state
// push, clear and unused-code transfers skip the arithmetic and go straight to decide
// arst_n clears the controller, queue counters and config (far multiplier to 4)
// in_stall is high while an item is in work; the next item is taken while a
//   finished result still waits on out_stall, and decide holds until it leaves

module object_distance_cone_cull #(
	parameter int QUEUE_A_CAP = odcc_pkg::QUEUE_A_CAP_DEF,
	parameter int QUEUE_B_CAP = odcc_pkg::QUEUE_B_CAP_DEF,
	parameter int QUEUE_C_CAP = odcc_pkg::QUEUE_C_CAP_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration writes
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  logic [31:0]         obj_handle,
	input  logic [7:0]          obj_type,
	input  logic signed [15:0]  delta_x,
	input  logic signed [15:0]  delta_y,
	input  logic signed [15:0]  delta_z,
	input  logic [2:0]          cull_state,
	input  logic [7:0]          mode_byte,
	input  logic                queue_suppress,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic                visible,
	output logic                forced_state_two,
	output logic [1:0]          queue_sel,
	output logic                pushed,
	output logic [5:0]          queue_count,
	output logic [31:0]         obj_out
);

	// commands from the sequencer, status back from the datapath
	odcc_pkg::cmd_t cmd;
	odcc_pkg::sts_t sts;

	// sequencer: accept, multiply schedule, root steps, decide and result valid
	odcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: config, item capture, shared multiplier, root unit, counters,
	// result register
	odcc_dp #(
		.QUEUE_A_CAP (QUEUE_A_CAP),
		.QUEUE_B_CAP (QUEUE_B_CAP),
		.QUEUE_C_CAP (QUEUE_C_CAP)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.func             (func),
		.obj_handle       (obj_handle),
		.obj_type         (obj_type),
		.delta_x          (delta_x),
		.delta_y          (delta_y),
		.delta_z          (delta_z),
		.cull_state       (cull_state),
		.mode_byte        (mode_byte),
		.queue_suppress   (queue_suppress),
		.visible          (visible),
		.forced_state_two (forced_state_two),
		.queue_sel        (queue_sel),
		.pushed           (pushed),
		.queue_count      (queue_count),
		.obj_out          (obj_out)
	);

endmodule

/* design/odcc_ctrl.sv */
`timescale 1ns / 1ps

module odcc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  odcc_pkg::sts_t   sts,
	output odcc_pkg::cmd_t   cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL    = 3'd1;
	localparam logic [2:0] ST_SQRT   = 3'd2;
	localparam logic [2:0] ST_THR    = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;
	localparam logic [2:0] ST_LAND   = 3'd5;

	localparam logic [3:0] SQRT_LAST = 4'(odcc_pkg::SQRT_STEPS - 1);

	logic [2:0] state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       out_vld_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
					cnt_d    = '0;
				end
			end
			ST_MUL: begin
				if (!sts.is_cull) begin
					state_d = ST_DECIDE;
				end else begin
					cmd.mul_go = 1'b1;
					cmd.mul_op = cnt_q[2:0];
					if (cnt_q[2:0] == odcc_pkg::MUL_FAR) begin
						// sum of squares has landed by now
						cmd.sqrt_init = 1'b1;
						state_d       = ST_SQRT;
						cnt_d         = '0;
					end else begin
						cnt_d = cnt_q + 4'd1;
					end
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == SQRT_LAST) begin
					state_d = ST_THR;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			ST_THR: begin
				cmd.mul_go = 1'b1;
				cmd.mul_op = odcc_pkg::MUL_THR;
				state_d    = ST_LAND;
			end
			ST_LAND: begin
				// threshold product is written to its register here
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!out_vld_q || !out_stall) begin
					cmd.decide = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.decide) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_vld_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |-> !(out_vld_q && out_stall))
		else $error("result register overwritten while stalled");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_MUL))
		else $error("accepted transfer did not start work");

	a_result_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> ($past(state_q) == ST_DECIDE))
		else $error("result appeared outside decide");

endmodule

/* design/odcc_dp.sv */
`timescale 1ns / 1ps

module odcc_dp #(
	parameter int QUEUE_A_CAP = odcc_pkg::QUEUE_A_CAP_DEF,
	parameter int QUEUE_B_CAP = odcc_pkg::QUEUE_B_CAP_DEF,
	parameter int QUEUE_C_CAP = odcc_pkg::QUEUE_C_CAP_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  odcc_pkg::cmd_t      cmd,
	output odcc_pkg::sts_t      sts,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [1:0]          func,
	input  logic [31:0]         obj_handle,
	input  logic [7:0]          obj_type,
	input  logic signed [15:0]  delta_x,
	input  logic signed [15:0]  delta_y,
	input  logic signed [15:0]  delta_z,
	input  logic [2:0]          cull_state,
	input  logic [7:0]          mode_byte,
	input  logic                queue_suppress,
	output logic                visible,
	output logic                forced_state_two,
	output logic [1:0]          queue_sel,
	output logic                pushed,
	output logic [5:0]          queue_count,
	output logic [31:0]         obj_out
);

	localparam logic [4:0] CAP_A = 5'(QUEUE_A_CAP);
	localparam logic [5:0] CAP_B = 6'(QUEUE_B_CAP);
	localparam logic [4:0] CAP_C = 5'(QUEUE_C_CAP);

	// configuration
	logic [3:0]         far_mult_q;
	logic signed [15:0] fwd_x_q, fwd_y_q, fwd_z_q;

	// captured item
	logic [1:0]         func_q;
	logic [31:0]        handle_q;
	logic [7:0]         type_q;
	logic signed [15:0] dx_q, dy_q, dz_q;
	logic [2:0]         eff_state_q;
	logic               forced_q;
	logic               suppress_q;

	// arithmetic
	logic signed [16:0] mul_a, mul_b;
	logic signed [33:0] prod_s1;
	logic [2:0]         tag_s1;
	logic               prod_vld_s1;
	logic [31:0]        sq_acc_q, dot_acc_q;
	logic [16:0]        far_q;
	logic [25:0]        thrd_q;
	logic [31:0]        rem_q;
	logic [30:0]        root_q, sq_bit_q;
	logic [31:0]        trial;

	// queue counters
	logic [4:0] cnt_a_q, cnt_c_q;
	logic [5:0] cnt_b_q;

	// result register
	logic        visible_q, forced_out_q, pushed_q;
	logic [1:0]  qsel_q;
	logic [5:0]  qcount_q;
	logic [31:0] obj_q;

	odcc_pkg::limits_t lim;
	logic [15:0] root_dist;
	logic        is_cull, is_push, in_range, depth_ok, keep, want_push, room, push_ok;
	logic [1:0]  cls, sel_n;
	logic [5:0]  next_cnt;

	assign lim       = odcc_pkg::limits_of(eff_state_q, type_q);
	assign root_dist = root_q[15:0];
	assign sts.is_cull = (func_q == odcc_pkg::FUNC_CULL);

	always_comb begin
		case (cmd.mul_op)
			odcc_pkg::MUL_SQ_X:  begin mul_a = {dx_q[15], dx_q};    mul_b = {dx_q[15], dx_q}; end
			odcc_pkg::MUL_SQ_Y:  begin mul_a = {dy_q[15], dy_q};    mul_b = {dy_q[15], dy_q}; end
			odcc_pkg::MUL_SQ_Z:  begin mul_a = {dz_q[15], dz_q};    mul_b = {dz_q[15], dz_q}; end
			odcc_pkg::MUL_DOT_X: begin mul_a = {fwd_x_q[15], fwd_x_q}; mul_b = {dx_q[15], dx_q}; end
			odcc_pkg::MUL_DOT_Y: begin mul_a = {fwd_y_q[15], fwd_y_q}; mul_b = {dy_q[15], dy_q}; end
			odcc_pkg::MUL_DOT_Z: begin mul_a = {fwd_z_q[15], fwd_z_q}; mul_b = {dz_q[15], dz_q}; end
			odcc_pkg::MUL_FAR:   begin mul_a = {4'b0, lim.far};     mul_b = {13'b0, far_mult_q}; end
			default:             begin mul_a = {7'b0, lim.thr};     mul_b = {1'b0, root_dist}; end
		endcase
	end

	assign trial = {1'b0, root_q} + {1'b0, sq_bit_q};

	// cull decision and queue choice
	always_comb begin
		is_cull   = (func_q == odcc_pkg::FUNC_CULL);
		is_push   = (func_q == odcc_pkg::FUNC_PUSH);
		in_range  = ({1'b0, root_dist} >= {6'b0, lim.near}) && ({1'b0, root_dist} < far_q);
		depth_ok  = $signed(dot_acc_q) >= $signed({4'b0, thrd_q, 2'b00});
		keep      = (eff_state_q >= odcc_pkg::STATE_KEEP_MIN) || (in_range && depth_ok);
		cls       = odcc_pkg::class_queue(type_q);
		want_push = is_push || (is_cull && keep && !suppress_q);
		sel_n     = want_push ? cls : odcc_pkg::QSEL_NONE;
		case (sel_n)
			odcc_pkg::QSEL_A: begin
				room     = (cnt_a_q < CAP_A);
				next_cnt = {1'b0, cnt_a_q + 5'd1};
			end
			odcc_pkg::QSEL_B: begin
				room     = (cnt_b_q < CAP_B);
				next_cnt = cnt_b_q + 6'd1;
			end
			odcc_pkg::QSEL_C: begin
				room     = (cnt_c_q < CAP_C);
				next_cnt = {1'b0, cnt_c_q + 5'd1};
			end
			default: begin
				room     = 1'b0;
				next_cnt = '0;
			end
		endcase
		push_ok = room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_mult_q  <= odcc_pkg::FAR_MULT_RESET;
			fwd_x_q     <= '0;
			fwd_y_q     <= '0;
			fwd_z_q     <= '0;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			cnt_c_q     <= '0;
			prod_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					odcc_pkg::REG_FAR_MULT:  far_mult_q <= cfg_data[3:0];
					odcc_pkg::REG_FORWARD_X: fwd_x_q    <= cfg_data;
					odcc_pkg::REG_FORWARD_Y: fwd_y_q    <= cfg_data;
					odcc_pkg::REG_FORWARD_Z: fwd_z_q    <= cfg_data;
					default: ;
				endcase
			end
			prod_vld_s1 <= cmd.mul_go;
			if (cmd.decide) begin
				if (func_q == odcc_pkg::FUNC_CLEAR) begin
					cnt_a_q <= '0;
					cnt_b_q <= '0;
					cnt_c_q <= '0;
				end else if (push_ok) begin
					case (sel_n)
						odcc_pkg::QSEL_A: cnt_a_q <= next_cnt[4:0];
						odcc_pkg::QSEL_B: cnt_b_q <= next_cnt;
						odcc_pkg::QSEL_C: cnt_c_q <= next_cnt[4:0];
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q      <= func;
			handle_q    <= obj_handle;
			type_q      <= obj_type;
			dx_q        <= delta_x;
			dy_q        <= delta_y;
			dz_q        <= delta_z;
			forced_q    <= (mode_byte == odcc_pkg::MODE_FORCE_TWO);
			eff_state_q <= (mode_byte == odcc_pkg::MODE_FORCE_TWO) ?
				odcc_pkg::STATE_FORCED : cull_state;
			suppress_q  <= queue_suppress;
		end

		prod_s1 <= mul_a * mul_b;
		tag_s1  <= cmd.mul_op;

		if (cmd.load) begin
			sq_acc_q  <= '0;
			dot_acc_q <= '0;
		end else if (prod_vld_s1) begin
			case (tag_s1)
				odcc_pkg::MUL_SQ_X, odcc_pkg::MUL_SQ_Y, odcc_pkg::MUL_SQ_Z:
					sq_acc_q <= sq_acc_q + prod_s1[31:0];
				odcc_pkg::MUL_DOT_X, odcc_pkg::MUL_DOT_Y, odcc_pkg::MUL_DOT_Z:
					dot_acc_q <= dot_acc_q + prod_s1[31:0];
				odcc_pkg::MUL_FAR:
					far_q <= prod_s1[16:0];
				default:
					thrd_q <= prod_s1[25:0];
			endcase
		end

		// one result bit per step
		if (cmd.sqrt_init) begin
			rem_q    <= sq_acc_q;
			root_q   <= '0;
			sq_bit_q <= 31'(1) << 30;
		end else if (cmd.sqrt_step) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + sq_bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end

		if (cmd.decide) begin
			visible_q    <= (is_cull && keep) || is_push;
			forced_out_q <= is_cull && forced_q;
			qsel_q       <= sel_n;
			pushed_q     <= push_ok;
			qcount_q     <= push_ok ? next_cnt : 6'd0;
			obj_q        <= (is_cull || is_push) ? handle_q : 32'd0;
		end
	end

	assign visible          = visible_q;
	assign forced_state_two = forced_out_q;
	assign queue_sel        = qsel_q;
	assign pushed           = pushed_q;
	assign queue_count      = qcount_q;
	assign obj_out          = obj_q;

	a_caps: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= CAP_A) && (cnt_b_q <= CAP_B) && (cnt_c_q <= CAP_C))
		else $error("queue counter above its cap");

	a_push_sel: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.decide) && pushed_q |-> (qsel_q != odcc_pkg::QSEL_NONE) && (qcount_q != 6'd0))
		else $error("push reported without a queue or count");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.decide) && $past(func_q == odcc_pkg::FUNC_CLEAR)
		|-> (cnt_a_q == 5'd0) && (cnt_b_q == 6'd0) && (cnt_c_q == 5'd0))
		else $error("clear left a queue counter set");

endmodule

/* tb/object_distance_cone_cull_tb.sv */
`timescale 1ns / 1ps

// self-checking bench for the distance and view-cone cull block
// every accepted object gets its verdict worked out here, from our own copy of
// the view registers and queue depths, and every verdict leaving the block is
// checked against the oldest one still due

module object_distance_cone_cull_tb;
	import odcc_pkg::*;

	localparam logic [1:0] FUNC_SPARE = 2'd3;    // unused function code
	localparam int A_CAP = QUEUE_A_CAP_DEF;
	localparam int B_CAP = QUEUE_B_CAP_DEF;
	localparam int C_CAP = QUEUE_C_CAP_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;            // long receiver hold-off
	localparam int GAP_MAX = 30;                 // longest sender gap
	localparam int DRAIN_CYCLES = 40;            // tail after the last verdict

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] handle;
		logic [7:0]  otype;
		logic [15:0] dx;
		logic [15:0] dy;
		logic [15:0] dz;
		logic [2:0]  cstate;
		logic [7:0]  mode;
		logic        suppress;
	} object_req_t;

	typedef struct packed {
		logic        visible;
		logic        forced;
		logic [1:0]  qsel;
		logic        pushed;
		logic [5:0]  qcount;
		logic [31:0] obj;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [31:0] obj_handle;
	logic [7:0]  obj_type;
	logic signed [15:0] delta_x;
	logic signed [15:0] delta_y;
	logic signed [15:0] delta_z;
	logic [2:0]  cull_state;
	logic [7:0]  mode_byte;
	logic        queue_suppress;
	logic        out_valid;
	logic        out_stall;
	logic        visible;
	logic        forced_state_two;
	logic [1:0]  queue_sel;
	logic        pushed;
	logic [5:0]  queue_count;
	logic [31:0] obj_out;

	// our copy of the view registers
	logic [3:0]  view_far_mult;
	logic [15:0] view_fwd_x;
	logic [15:0] view_fwd_y;
	logic [15:0] view_fwd_z;

	// our copy of the render-queue depths
	logic [4:0]  depth_a;
	logic [5:0]  depth_b;
	logic [4:0]  depth_c;

	verdict_t verdicts_due[$];
	int fail_count;
	int cycle_count;
	int send_idle_pct;
	int recv_stall_pct;

	// hold-off requests: the stimulus bumps the token, the receiver counts
	int hold_token;
	int hold_seen;
	int hold_left;

	object_distance_cone_cull u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.obj_handle       (obj_handle),
		.obj_type         (obj_type),
		.delta_x          (delta_x),
		.delta_y          (delta_y),
		.delta_z          (delta_z),
		.cull_state       (cull_state),
		.mode_byte        (mode_byte),
		.queue_suppress   (queue_suppress),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.visible          (visible),
		.forced_state_two (forced_state_two),
		.queue_sel        (queue_sel),
		.pushed           (pushed),
		.queue_count      (queue_count),
		.obj_out          (obj_out)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// floor square root, one result bit per pass from the top
	function automatic logic [15:0] root_floor(logic [31:0] v);
		logic [15:0] r;
		logic [15:0] trial;
		r = '0;
		for (int i = 15; i >= 0; i--) begin
			trial = r | (16'd1 << i);
			if (longint'(trial) * longint'(trial) <= longint'(v))
				r = trial;
		end
		return r;
	endfunction

	function automatic logic [31:0] square16(logic [15:0] x);
		int sx;
		sx = int'($signed(x));
		return 32'(sx * sx);
	endfunction

	function automatic logic [1:0] queue_for_type(logic [7:0] t);
		if (t == TYPE_A0 || t == TYPE_A1)
			return QSEL_A;
		else if (t == TYPE_B)
			return QSEL_B;
		else if (t == TYPE_C)
			return QSEL_C;
		return QSEL_NONE;
	endfunction

	// take a slot in the chosen queue; new depth, or zero when it is full
	function automatic logic [5:0] take_slot(logic [1:0] sel);
		logic [5:0] n;
		n = '0;
		case (sel)
			QSEL_A: if (depth_a < A_CAP) begin
				depth_a = depth_a + 5'd1;
				n = 6'(depth_a);
			end
			QSEL_B: if (depth_b < B_CAP) begin
				depth_b = depth_b + 6'd1;
				n = depth_b;
			end
			QSEL_C: if (depth_c < C_CAP) begin
				depth_c = depth_c + 5'd1;
				n = 6'(depth_c);
			end
			default: n = '0;
		endcase
		return n;
	endfunction

	function automatic verdict_t compute_verdict(object_req_t r);
		verdict_t v;
		logic [2:0] st;
		logic [31:0] sq_total;
		logic [15:0] span;
		int near_lim;
		int far_base;
		int thr;
		int dot;
		longint far_lim;
		longint quot;
		logic keep;
		v = '0;
		keep = 1'b0;
		case (r.func)
			FUNC_CULL: begin
				sq_total = square16(r.dx) + square16(r.dy) + square16(r.dz);
				span = root_floor(sq_total);
				v.obj = r.handle;
				st = r.cstate;
				if (r.mode == MODE_FORCE_TWO) begin
					v.forced = 1'b1;
					st = STATE_FORCED;
				end
				if (st >= STATE_KEEP_MIN) begin
					keep = 1'b1;
				end else begin
					case (st)
						3'd0: begin
							near_lim = 512;
							if (r.otype == TYPE_B) begin
								far_base = 7169;
								thr = 856;
							end else if (r.otype == TYPE_A0 || r.otype == TYPE_A1) begin
								far_base = 5121;
								thr = 880;
							end else if (r.otype == TYPE_C) begin
								far_base = 6657;
								thr = 872;
							end else begin
								far_base = 6145;
								thr = 872;
							end
						end
						3'd1: begin
							near_lim = 512;
							far_base = 7169;
							thr = 856;
						end
						3'd2: begin
							near_lim = 768;
							far_base = 4097;
							thr = 880;
						end
						3'd3: begin
							near_lim = 512;
							far_base = 4097;
							thr = 848;
						end
						default: begin
							near_lim = 1024;
							far_base = 6657;
							thr = 872;
						end
					endcase
					far_lim = longint'(far_base) * longint'(int'(view_far_mult));
					if (longint'(span) >= near_lim && longint'(span) < far_lim) begin
						// 32-bit sum, wraps like the hardware accumulator
						dot = int'($signed(view_fwd_x)) * int'($signed(r.dx))
							+ int'($signed(view_fwd_y)) * int'($signed(r.dy))
							+ int'($signed(view_fwd_z)) * int'($signed(r.dz));
						quot = longint'(dot) / (longint'(span) * 4);
						if (quot >= longint'(thr))
							keep = 1'b1;
					end
				end
				v.visible = keep;
				if (keep && !r.suppress) begin
					v.qsel = queue_for_type(r.otype);
					if (v.qsel != QSEL_NONE) begin
						v.qcount = take_slot(v.qsel);
						v.pushed = (v.qcount != 0);
					end
				end
			end
			FUNC_PUSH: begin
				v.obj = r.handle;
				v.visible = 1'b1;
				v.qsel = queue_for_type(r.otype);
				if (v.qsel != QSEL_NONE) begin
					v.qcount = take_slot(v.qsel);
					v.pushed = (v.qcount != 0);
				end
			end
			FUNC_CLEAR: begin
				depth_a = '0;
				depth_b = '0;
				depth_c = '0;
			end
			default: v = '0;
		endcase
		return v;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic object_req_t make_req(logic [1:0] f, logic [31:0] h, logic [7:0] t,
			int x, int y, int z, logic [2:0] s, logic [7:0] m, logic q);
		object_req_t r;
		r.func = f;
		r.handle = h;
		r.otype = t;
		r.dx = 16'(x);
		r.dy = 16'(y);
		r.dz = 16'(z);
		r.cstate = s;
		r.mode = m;
		r.suppress = q;
		return r;
	endfunction

	function automatic logic [15:0] clip16(int v);
		if (v > 32767)
			return 16'h7fff;
		if (v < -32768)
			return 16'h8000;
		return 16'(v);
	endfunction

	function automatic logic [15:0] extreme16();
		case ($urandom_range(3))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'hffff;
		endcase
	endfunction

	// a delta component roughly along the forward axis, scaled by num/2048
	function automatic logic [15:0] steer(logic [15:0] f, int num);
		return clip16(int'($signed(f)) * num / 2048 + int'($urandom_range(0, 300)) - 150);
	endfunction

	function automatic object_req_t draw_object(bit filling);
		object_req_t r;
		int pick;
		int num;
		r.handle = $urandom;
		r.mode = ($urandom_range(9) == 0) ? MODE_FORCE_TWO : 8'($urandom);
		r.suppress = ($urandom_range(3) == 0);
		r.cstate = ($urandom_range(3) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
		pick = $urandom_range(99);
		if (filling)
			r.func = (pick < 85) ? FUNC_PUSH : FUNC_CULL;
		else if (pick < 80)
			r.func = FUNC_CULL;
		else if (pick < 88)
			r.func = FUNC_PUSH;
		else if (pick < 94)
			r.func = FUNC_CLEAR;
		else
			r.func = FUNC_SPARE;
		// queue classes weighted so the larger queue also reaches its cap
		if (filling || $urandom_range(1) == 0) begin
			pick = $urandom_range(99);
			if (pick < 13)
				r.otype = TYPE_A0;
			else if (pick < 25)
				r.otype = TYPE_A1;
			else if (pick < 70)
				r.otype = TYPE_B;
			else
				r.otype = TYPE_C;
		end else begin
			r.otype = 8'($urandom);
		end
		pick = $urandom_range(99);
		if (pick < 50) begin
			// mostly in front of the camera, some behind
			num = int'($urandom_range(0, 700)) - 100;
			r.dx = steer(view_fwd_x, num);
			r.dy = steer(view_fwd_y, num);
			r.dz = steer(view_fwd_z, num);
		end else if (pick < 70) begin
			r.dx = 16'(int'($urandom_range(0, 2400)) - 1200);
			r.dy = 16'(int'($urandom_range(0, 2400)) - 1200);
			r.dz = 16'(int'($urandom_range(0, 2400)) - 1200);
		end else if (pick < 90) begin
			r.dx = 16'($urandom);
			r.dy = 16'($urandom);
			r.dz = 16'($urandom);
		end else begin
			r.dx = extreme16();
			r.dy = extreme16();
			r.dz = extreme16();
		end
		return r;
	endfunction

	// one input transfer; returns just after the accepting edge with valid
	// still up, so a back-to-back object can follow in the same step
	task automatic offer(object_req_t r);
		int gap;
		gap = 0;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
			gap = $urandom_range(1, GAP_MAX);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= r.func;
		obj_handle <= r.handle;
		obj_type <= r.otype;
		delta_x <= r.dx;
		delta_y <= r.dy;
		delta_z <= r.dz;
		cull_state <= r.cstate;
		mode_byte <= r.mode;
		queue_suppress <= r.suppress;
		do @(posedge clk); while (in_stall);
		verdicts_due.push_back(compute_verdict(r));
	endtask

	// stop offering and wait until every verdict has come out
	task automatic wait_idle(int settle);
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// reprogram the view only while the block is idle
	task automatic program_view(logic [3:0] mult, logic [15:0] fx, logic [15:0] fy,
			logic [15:0] fz);
		wait_idle(4);
		write_reg(REG_FAR_MULT, {12'd0, mult});
		write_reg(REG_FORWARD_X, fx);
		write_reg(REG_FORWARD_Y, fy);
		write_reg(REG_FORWARD_Z, fz);
		cfg_we <= 1'b0;
		view_far_mult = mult;
		view_fwd_x = fx;
		view_fwd_y = fy;
		view_fwd_z = fz;
	endtask

	task automatic run_random(int n, int idle_pct, int stall_pct, bit filling);
		send_idle_pct = idle_pct;
		recv_stall_pct <= stall_pct;
		repeat (n) offer(draw_object(filling));
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset view: zero forward vector, so only the always-keep states pass
	task automatic test_reset_defaults();
		offer(make_req(FUNC_CULL, 32'hffffffff, TYPE_A0, 100, 0, 0, 3'd5, 8'd0, 1'b0));
		offer(make_req(FUNC_CULL, 32'h00000000, TYPE_B, -100, 0, 0, 3'd7, 8'hff, 1'b0));
		offer(make_req(FUNC_CULL, 32'h12345678, TYPE_C, 0, 100, 0, 3'd6, 8'd0, 1'b0));
		// kept but pushing suppressed
		offer(make_req(FUNC_CULL, 32'h87654321, TYPE_A1, 0, 0, 100, 3'd5, 8'd0, 1'b1));
		// mode byte forces state two, too close to keep
		offer(make_req(FUNC_CULL, 32'h0badcafe, TYPE_A1, 100, 0, 0, 3'd7, MODE_FORCE_TWO,
			1'b0));
		offer(make_req(FUNC_CULL, 32'h55aa55aa, TYPE_A0, 1000, 0, 0, 3'd0, 8'd0, 1'b0));
		offer(make_req(FUNC_PUSH, 32'haa55aa55, TYPE_B, 0, 0, 0, 3'd0, 8'd0, 1'b1));
		offer(make_req(FUNC_PUSH, 32'h00000001, 8'd0, 0, 0, 0, 3'd0, 8'd0, 1'b0));
		offer(make_req(FUNC_PUSH, 32'h80000000, 8'hff, 0, 0, 0, 3'd0, 8'd0, 1'b0));
		offer(make_req(FUNC_SPARE, 32'hdeadbeef, TYPE_B, -32768, 32767, -1, 3'd7,
			8'hff, 1'b1));
		offer(make_req(FUNC_CLEAR, 32'hffffffff, TYPE_C, 1, 1, 1, 3'd5, 8'd0, 1'b0));
		offer(make_req(FUNC_PUSH, 32'h7fffffff, TYPE_C, 0, 0, 0, 3'd0, 8'd0, 1'b0));
	endtask

	// near and far bounds and the depth threshold, along the x axis
	task automatic test_cone_edges();
		program_view(4'd1, 16'd3520, 16'd0, 16'd0);
		offer(make_req(FUNC_CULL, 32'h1, 8'd7, 1000, 0, 0, 3'd2, 8'd0, 1'b0));
		offer(make_req(FUNC_CULL, 32'h2, TYPE_A0, 767, 0, 0, 3'd2, 8'd0, 1'b0));
		offer(make_req(FUNC_CULL, 32'h3, TYPE_A0, 768, 0, 0, 3'd2, 8'd0, 1'b0));
		offer(make_req(FUNC_CULL, 32'h4, TYPE_B, 4096, 0, 0, 3'd3, 8'd0, 1'b0));
		offer(make_req(FUNC_CULL, 32'h5, TYPE_B, 4097, 0, 0, 3'd3, 8'd0, 1'b0));
		offer(make_req(FUNC_CULL, 32'h6, TYPE_C, -2000, 0, 0, 3'd1, 8'd0, 1'b0));
		offer(make_req(FUNC_CULL, 32'h7, TYPE_C, 1023, 0, 0, 3'd4, 8'd0, 1'b0));
		offer(make_req(FUNC_CULL, 32'h8, TYPE_C, 1024, 0, 0, 3'd4, 8'd0, 1'b0));
		// one step short of the threshold
		program_view(4'd1, 16'd3519, 16'd0, 16'd0);
		offer(make_req(FUNC_CULL, 32'h9, TYPE_A0, 1000, 0, 0, 3'd2, 8'd0, 1'b0));
	endtask

	// dot product wrapping both ways, widest and zero far multiplier
	task automatic test_dot_wrap();
		program_view(4'd15, 16'h8000, 16'h8000, 16'h8000);
		offer(make_req(FUNC_CULL, 32'ha, TYPE_B, -32768, -32768, -32768, 3'd4, 8'd0, 1'b0));
		offer(make_req(FUNC_CULL, 32'hb, TYPE_B, 32767, 32767, 32767, 3'd4, 8'd0, 1'b0));
		program_view(4'd0, 16'h7fff, 16'h7fff, 16'h7fff);
		offer(make_req(FUNC_CULL, 32'hc, TYPE_A1, 1000, 1000, 1000, 3'd0, 8'd0, 1'b0));
		offer(make_req(FUNC_CULL, 32'hd, TYPE_A1, 1000, 1000, 1000, 3'd5, 8'd0, 1'b0));
	endtask

	task automatic test_free_flow();
		program_view(4'd8, 16'($urandom), 16'($urandom), 16'($urandom));
		run_random(135, 0, 0, 1'b0);
	endtask

	task automatic test_sender_gaps();
		program_view(4'd1, 16'h7fff, 16'h8000, 16'($urandom));
		run_random(135, 69, 0, 1'b0);
	endtask

	task automatic test_receiver_stalls();
		program_view(4'($urandom_range(15)), 16'($urandom), 16'($urandom), 16'($urandom));
		run_random(135, 0, 69, 1'b0);
	endtask

	// long receiver hold-off while objects keep coming, then random stalls
	task automatic test_backpressure();
		program_view(4'd15, 16'($urandom), 16'($urandom), 16'($urandom));
		hold_token <= hold_token + 1;
		run_random(135, 36, 36, 1'b0);
	endtask

	// one clear first, then no clears and mostly class pushes: all three queues run into their caps
	task automatic test_queue_caps();
		program_view(4'd4, 16'($urandom), 16'($urandom), 16'($urandom));
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		offer(make_req(FUNC_CLEAR, 32'h0, 8'd0, 0, 0, 0, 3'd0, 8'd0, 1'b0));
		run_random(160, 0, 0, 1'b1);
	endtask

	// ------------------------------------------------------------------
	// receiver, checker, watchdog
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// every output transfer is checked against the oldest verdict still due
	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{visible, forced_state_two, queue_sel, pushed, queue_count, obj_out};
			if (verdicts_due.size() == 0) begin
				if (fail_count < 10)
					$display("%0t: result with nothing due: vis %0b fst %0b sel %0d push %0b cnt %0d obj %h",
						$time, got.visible, got.forced, got.qsel, got.pushed, got.qcount, got.obj);
				fail_count++;
			end else begin
				want = verdicts_due.pop_front();
				if (got !== want) begin
					if (fail_count < 10)
						$display("%0t: mismatch: want vis %0b fst %0b sel %0d push %0b cnt %0d obj %h, got vis %0b fst %0b sel %0d push %0b cnt %0d obj %h",
							$time, want.visible, want.forced, want.qsel, want.pushed,
							want.qcount, want.obj, got.visible, got.forced, got.qsel,
							got.pushed, got.qcount, got.obj);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("object_distance_cone_cull_tb: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		fail_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_token = 0;
		hold_seen = 0;
		hold_left = 0;
		// predictor starts from the reset state of the block
		view_far_mult = FAR_MULT_RESET;
		view_fwd_x = '0;
		view_fwd_y = '0;
		view_fwd_z = '0;
		depth_a = '0;
		depth_b = '0;
		depth_c = '0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FAR_MULT;
		cfg_data <= '0;
		in_valid <= 1'b0;
		func <= FUNC_CULL;
		obj_handle <= '0;
		obj_type <= '0;
		delta_x <= '0;
		delta_y <= '0;
		delta_z <= '0;
		cull_state <= '0;
		mode_byte <= '0;
		queue_suppress <= 1'b0;
		out_stall <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_cone_edges();
		test_dot_wrap();
		test_free_flow();
		test_sender_gaps();
		test_receiver_stalls();
		test_backpressure();
		test_queue_caps();

		// let everything drain, then watch a little longer for strays
		wait_idle(DRAIN_CYCLES);
		if (fail_count == 0)
			$display("object_distance_cone_cull_tb: PASS");
		else
			$display("object_distance_cone_cull_tb: FAIL");
		$finish;
	end

endmodule
